/* rtl/core/crr_pkg.sv */
// Shared constants, register indexes and color expansion tables for the
// center-crop / nearest-neighbor resize unit. No dependencies.
`default_nettype none

package crr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned OUT_CRD_W   = 7;

  // Register reset values
  localparam int unsigned FRAME_WIDTH_RST  = 320;
  localparam int unsigned FRAME_HEIGHT_RST = 240;

  // Default sizes for the top-level parameters
  localparam int unsigned OUT_WIDTH_DEF     = 96;
  localparam int unsigned OUT_HEIGHT_DEF    = 96;
  localparam int unsigned MAX_FRAME_DIM_DEF = 2048;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [31:0][CH_W-1:0] exp5_lut_t;
  typedef logic [63:0][CH_W-1:0] exp6_lut_t;

  // v * 255 / 31, rounded down, for every 5-bit code
  function automatic exp5_lut_t gen_exp5();
    exp5_lut_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = CH_W'((i * 255) / 31);
    end
    return lut;
  endfunction

  // v * 255 / 63, rounded down, for every 6-bit code
  function automatic exp6_lut_t gen_exp6();
    exp6_lut_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = CH_W'((i * 255) / 63);
    end
    return lut;
  endfunction

  localparam exp5_lut_t EXP5_LUT = gen_exp5();
  localparam exp6_lut_t EXP6_LUT = gen_exp6();

endpackage

`default_nettype wire

/* rtl/core/crop_resize_rgb565_to_rgb888_unit.sv */
// Center-crop and nearest-neighbor downscale of an RGB565 pixel stream to RGB888.
// Depends on crr_pkg (widths, register indexes, expansion tables).
`default_nettype none

// Usage
//   Input channel: pixel_i / frame_start_i with in_valid_i, in_stall_o. One item
//   is one source pixel in raster order; frame_start_i marks the first pixel of
//   a frame and returns source and output positions to zero.
//   Output channel: red/green/blue, out_col/out_row, frame_done with
//   out_valid_o, out_stall_i. Only source pixels picked by the resize give an
//   item; frame_done flags the last output pixel of the frame.
//   Config: cfg_we_i writes cfg_data_i into frame_width (index 0) or
//   frame_height (index 1). Values are clamped to the downscale range inside.
//   Throughput: one pixel per clock while the output is not stalled. An item
//   accepted into the input register passes its result to the result register.
//   Datapath: input register -> position compare (one col*side multiply and a
//   constant multiply per axis) and channel tables -> result register.
//   Stall: a result waits in the result register; the input register still
//   fills, and in_stall_o rises only while both registers are held.
//   Reset: registers return to 320 x 240, all counters to zero, no item held.
module crop_resize_rgb565_to_rgb888_unit #(
  parameter int unsigned OUT_WIDTH     = crr_pkg::OUT_WIDTH_DEF,
  parameter int unsigned OUT_HEIGHT    = crr_pkg::OUT_HEIGHT_DEF,
  parameter int unsigned MAX_FRAME_DIM = crr_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // config write port
  input  wire                           cfg_we_i,
  input  wire                           cfg_idx_i,
  input  wire [crr_pkg::CFG_W-1:0]      cfg_data_i,
  // source pixels
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [crr_pkg::PIX_W-1:0]      pixel_i,
  input  wire                           frame_start_i,
  // resized pixels
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [crr_pkg::CH_W-1:0]      red_o,
  output logic [crr_pkg::CH_W-1:0]      green_o,
  output logic [crr_pkg::CH_W-1:0]      blue_o,
  output logic [crr_pkg::OUT_CRD_W-1:0] out_col_o,
  output logic [crr_pkg::OUT_CRD_W-1:0] out_row_o,
  output logic                          frame_done_o
);
  import crr_pkg::*;

  // dimension values run up to MAX_FRAME_DIM, positions stay below it
  localparam int unsigned DW     = $clog2(MAX_FRAME_DIM + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_DIM);
  localparam int unsigned EW     = (CFG_W > DW) ? CFG_W : DW;
  localparam int unsigned DIM_LO = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
  localparam int unsigned OCW    = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int unsigned ORW    = $clog2(OUT_HEIGHT + 1);
  // compare widths: index*side and offset*OUT+OUT both stay at or below MAX*OUT
  localparam int unsigned MWC    = DW + $clog2(OUT_WIDTH + 1) + 1;
  localparam int unsigned MWR    = DW + $clog2(OUT_HEIGHT + 1) + 1;

  // crop geometry that follows from the reset frame size
  localparam int unsigned RST_W_EFF = (FRAME_WIDTH_RST < DIM_LO) ? DIM_LO :
      (FRAME_WIDTH_RST > MAX_FRAME_DIM) ? MAX_FRAME_DIM : FRAME_WIDTH_RST;
  localparam int unsigned RST_H_EFF = (FRAME_HEIGHT_RST < DIM_LO) ? DIM_LO :
      (FRAME_HEIGHT_RST > MAX_FRAME_DIM) ? MAX_FRAME_DIM : FRAME_HEIGHT_RST;
  localparam int unsigned RST_SIDE  = (RST_W_EFF < RST_H_EFF) ? RST_W_EFF : RST_H_EFF;
  localparam int unsigned RST_CX    = (RST_W_EFF - RST_SIDE) / 2;
  localparam int unsigned RST_CY    = (RST_H_EFF - RST_SIDE) / 2;

  // clamp a register value into the downscale range
  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve < EW'(DIM_LO)) begin
      return DW'(DIM_LO);
    end else if (ve > EW'(MAX_FRAME_DIM)) begin
      return DW'(MAX_FRAME_DIM);
    end else begin
      return DW'(ve);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers and derived crop geometry
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [DW-1:0]    w_eff, h_eff, side_d, side_q, w_q, crop_x_d, crop_x_q, crop_y_d, crop_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(FRAME_WIDTH_RST);
      frame_height_q <= CFG_W'(FRAME_HEIGHT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default:          frame_width_q  <= frame_width_q;
      endcase
    end
  end

  // Geometry is registered; the input register gives it time to settle
  // after a write before the next pixel reaches the compare.
  always_comb begin
    w_eff    = eff_dim(frame_width_q);
    h_eff    = eff_dim(frame_height_q);
    side_d   = (w_eff < h_eff) ? w_eff : h_eff;
    crop_x_d = (w_eff - side_d) >> 1;
    crop_y_d = (h_eff - side_d) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= DW'(RST_W_EFF);
      side_q   <= DW'(RST_SIDE);
      crop_x_q <= DW'(RST_CX);
      crop_y_q <= DW'(RST_CY);
    end else begin
      w_q      <= w_eff;
      side_q   <= side_d;
      crop_x_q <= crop_x_d;
      crop_y_q <= crop_y_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register and result register
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [PIX_W-1:0]    s1_pixel_q;
  logic                s1_fs_q;
  logic                out_valid_q;
  logic                advance, in_accept, hit;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pixel_i;
      s1_fs_q    <= frame_start_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Position tracking and pixel pick
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] src_col_q, src_row_q, src_col_d, src_row_d;
  logic [OCW-1:0]   nxt_col_q, nxt_col_d;
  logic [ORW-1:0]   nxt_row_q, nxt_row_d;

  logic [CNT_W-1:0] col, row;
  logic [OCW-1:0]   nc;
  logic [ORW-1:0]   nr;
  logic [DW-1:0]    col_off, row_off;
  logic [MWC-1:0]   lhs_c, rhs_c;
  logic [MWR-1:0]   lhs_r, rhs_r;
  logic             col_hit, row_hit, last;

  always_comb begin
    // frame start puts this pixel at the origin
    col = s1_fs_q ? '0 : src_col_q;
    row = s1_fs_q ? '0 : src_row_q;
    nc  = s1_fs_q ? '0 : nxt_col_q;
    nr  = s1_fs_q ? '0 : nxt_row_q;
    // a shrunk width wraps the column at once
    if (DW'(col) >= w_q) begin
      col = '0;
    end

    // source column x is picked by output column c when
    // (x - crop_x) * OUT_WIDTH <= c * side < (x - crop_x + 1) * OUT_WIDTH
    col_off = DW'(col) - crop_x_q;
    lhs_c   = MWC'(nc) * MWC'(side_q);
    rhs_c   = MWC'(col_off) * MWC'(OUT_WIDTH);
    col_hit = (DW'(col) >= crop_x_q) && (lhs_c >= rhs_c) &&
              (lhs_c < rhs_c + MWC'(OUT_WIDTH));

    row_off = DW'(row) - crop_y_q;
    lhs_r   = MWR'(nr) * MWR'(side_q);
    rhs_r   = MWR'(row_off) * MWR'(OUT_HEIGHT);
    row_hit = (DW'(row) >= crop_y_q) && (lhs_r >= rhs_r) &&
              (lhs_r < rhs_r + MWR'(OUT_HEIGHT));

    hit  = (nr < ORW'(OUT_HEIGHT)) && (32'(nc) < OUT_WIDTH) && col_hit && row_hit;
    last = (32'(nc) == OUT_WIDTH - 1) && (32'(nr) == OUT_HEIGHT - 1);

    // next output position
    nxt_col_d = nc;
    nxt_row_d = nr;
    if (hit) begin
      if (32'(nc) + 1 >= OUT_WIDTH) begin
        nxt_col_d = '0;
        nxt_row_d = nr + 1'b1;
      end else begin
        nxt_col_d = nc + 1'b1;
      end
    end

    // next source position; row count sticks at the last row
    if (DW'(col) + 1'b1 >= w_q) begin
      src_col_d = '0;
      src_row_d = (32'(row) < MAX_FRAME_DIM - 1) ? row + 1'b1 : row;
    end else begin
      src_col_d = col + 1'b1;
      src_row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      nxt_col_q <= '0;
      nxt_row_q <= '0;
    end else if (advance) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      nxt_col_q <= nxt_col_d;
      nxt_row_q <= nxt_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= hit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit) begin
      red_o        <= EXP5_LUT[s1_pixel_q[15:11]];
      green_o      <= EXP6_LUT[s1_pixel_q[10:5]];
      blue_o       <= EXP5_LUT[s1_pixel_q[4:0]];
      out_col_o    <= OUT_CRD_W'(nc);
      out_row_o    <= OUT_CRD_W'(nr);
      frame_done_o <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
